[rtl/core/pctd_pkg.sv]
// Shared constants and types for the prime count block.
// No dependencies; used by pctd_rem and prime_count_trial_division.
package pctd_pkg;

  localparam int VALUE_W      = 32;
  localparam int MAG_W        = VALUE_W - 1;
  localparam int COUNT_W      = 17;
  localparam int DIV_W        = 16;
  localparam int SQ_W         = 32;
  localparam int OUT_TDATA_W  = 24;
  localparam int BITS_PER_CYC = 2;
  localparam int REM_STEPS    = VALUE_W / BITS_PER_CYC;
  localparam int STEP_W       = $clog2(REM_STEPS);
  localparam int DEFAULT_MAX_ELEMENTS = 65536;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_TEST = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
  } rem_ctl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

[rtl/core/pctd_rem.sv]
// Iterative remainder unit: restoring division, two dividend bits a cycle.
// Depends on pctd_pkg.
module pctd_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pctd_pkg::rem_ctl_t           ctl,
  input  logic [pctd_pkg::MAG_W-1:0]   dividend,
  input  logic [pctd_pkg::DIV_W-1:0]   divisor,
  output pctd_pkg::rem_sts_t           sts
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [pctd_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [pctd_pkg::VALUE_W-1:0]  dvd_r, dvd_nxt;
  logic [pctd_pkg::DIV_W-1:0]    rem_r, rem_nxt;
  logic [pctd_pkg::DIV_W:0]      r1, r2, dext;
  logic [pctd_pkg::DIV_W-1:0]    r1_fix;

  always_comb begin
    dext     = {1'b0, divisor};
    r1       = {rem_r, dvd_r[pctd_pkg::VALUE_W-1]};
    r1_fix   = (r1 >= dext) ? pctd_pkg::DIV_W'(r1 - dext) : r1[pctd_pkg::DIV_W-1:0];
    r2       = {r1_fix, dvd_r[pctd_pkg::VALUE_W-2]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = {1'b0, dividend};
      rem_nxt  = '0;
    end else if (busy_r) begin
      // two compare-subtract steps, shift two bits out of the dividend
      rem_nxt  = (r2 >= dext) ? pctd_pkg::DIV_W'(r2 - dext) : r2[pctd_pkg::DIV_W-1:0];
      dvd_nxt  = {dvd_r[pctd_pkg::VALUE_W-3:0], 2'b00};
      step_nxt = step_r + 1'b1;
      if (step_r == pctd_pkg::STEP_W'(pctd_pkg::REM_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

endmodule

[rtl/core/prime_count_trial_division.sv]
// Sequence: values below 3 or even are settled in S_INIT; odd values run, per odd trial
//   divisor, a square compare in S_TEST, the remainder steps and a done strobe in S_DIV,
//   for up to about 23170 divisors in the worst case.
// Throughput: one request at a time, paced by 2-bit-per-cycle remainder and out_tready.
// Reset (rst_n low, synchronous): sequencer idle, result channel empty, count zero.
// Depends on pctd_pkg and pctd_rem.
module prime_count_trial_division #(
  parameter int MAX_ELEMENTS = pctd_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pctd_pkg::VALUE_W-1:0]      in_tdata,   // [31:0] value (signed)
  input  logic                              in_tlast,   // last_element
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pctd_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [0] is_prime, [17:1] prime_count
  output logic                              out_tlast   // count_final
);

  // Count saturates at MAX_ELEMENTS or the largest count value, whichever is lower.
  localparam int COUNT_MAX = (1 << pctd_pkg::COUNT_W) - 1;
  localparam logic [pctd_pkg::COUNT_W-1:0] COUNT_CAP =
    pctd_pkg::COUNT_W'((MAX_ELEMENTS > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS);

  pctd_pkg::state_t               state_r, state_nxt;
  logic [pctd_pkg::MAG_W-1:0]     val_r, val_nxt;
  logic                           neg_r, neg_nxt;
  logic                           last_r, last_nxt;
  logic [pctd_pkg::DIV_W-1:0]     d_r, d_nxt;
  logic [pctd_pkg::SQ_W-1:0]      sq_r, sq_nxt;
  logic                           prime_r, prime_nxt;
  logic [pctd_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_prime_r, out_prime_nxt;
  logic [pctd_pkg::COUNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           in_acc;
  logic                           load;
  logic                           sq_over;
  logic [pctd_pkg::COUNT_W-1:0]   cnt_upd;
  pctd_pkg::rem_ctl_t             rem_ctl;
  pctd_pkg::rem_sts_t             rem_sts;

  assign in_tready = (state_r == pctd_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // divisor square already beyond the value: no divisor left to try
  assign sq_over   = (sq_r > pctd_pkg::SQ_W'(val_r));
  // result register free, or being emptied this cycle
  assign load      = (state_r == pctd_pkg::S_DONE) && (!out_valid_r || out_tready);
  assign cnt_upd   = (prime_r && (cnt_r < COUNT_CAP)) ? cnt_r + 1'b1 : cnt_r;

  assign rem_ctl.start = (state_r == pctd_pkg::S_TEST) && !sq_over;

  pctd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (val_r),
    .divisor  (d_r),
    .sts      (rem_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    cnt_nxt       = cnt_r;
    out_prime_nxt = out_prime_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      pctd_pkg::S_IDLE: begin
        if (in_acc) begin
          // capture magnitude bits and sign apart
          val_nxt   = in_tdata[pctd_pkg::MAG_W-1:0];
          neg_nxt   = in_tdata[pctd_pkg::VALUE_W-1];
          last_nxt  = in_tlast;
          state_nxt = pctd_pkg::S_INIT;
        end
      end
      pctd_pkg::S_INIT: begin
        if (neg_r || (val_r < pctd_pkg::MAG_W'(2))) begin
          prime_nxt = 1'b0;
          state_nxt = pctd_pkg::S_DONE;
        end else if (!val_r[0]) begin
          // even: prime only when the value is two
          prime_nxt = (val_r == pctd_pkg::MAG_W'(2));
          state_nxt = pctd_pkg::S_DONE;
        end else begin
          d_nxt     = pctd_pkg::DIV_W'(3);
          sq_nxt    = pctd_pkg::SQ_W'(9);
          state_nxt = pctd_pkg::S_TEST;
        end
      end
      pctd_pkg::S_TEST: begin
        if (sq_over) begin
          prime_nxt = 1'b1;
          state_nxt = pctd_pkg::S_DONE;
        end else begin
          state_nxt = pctd_pkg::S_DIV;
        end
      end
      pctd_pkg::S_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            prime_nxt = 1'b0;
            state_nxt = pctd_pkg::S_DONE;
          end else begin
            // advance to next odd divisor: (d+2)^2 = d^2 + 4d + 4
            sq_nxt    = sq_r + pctd_pkg::SQ_W'({d_r, 2'b00}) + pctd_pkg::SQ_W'(4);
            d_nxt     = d_r + pctd_pkg::DIV_W'(2);
            state_nxt = pctd_pkg::S_TEST;
          end
        end
      end
      pctd_pkg::S_DONE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
          out_cnt_nxt   = cnt_upd;
          out_last_nxt  = last_r;
          // drop the count once the matrix ends
          cnt_nxt       = last_r ? '0 : cnt_upd;
          state_nxt     = pctd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pctd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pctd_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r       <= val_nxt;
    neg_r       <= neg_nxt;
    last_r      <= last_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pctd_pkg::OUT_TDATA_W - pctd_pkg::COUNT_W - 1){1'b0}},
                       out_cnt_r, out_prime_r};
  assign out_tlast  = out_last_r;

  // Assertions
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_CAP)
    else $error("running count above cap");

  a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_sts.done |-> state_r == pctd_pkg::S_DIV)
    else $error("remainder done outside divide state");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_r) |=> cnt_r == '0)
    else $error("count not cleared after last element");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && out_cnt_r <= COUNT_CAP)
    else $error("result not presented after load");

  a_test_even_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pctd_pkg::S_TEST) |-> d_r[0] && val_r[0])
    else $error("trial divisor or value not odd");

endmodule
